[hdl/cbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and codes for the ring-store deque
// Item layouts of the command and result channels, operation and status codes.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int COUNT_W  = 11;

    // Operation codes; codes above OP_QUERY act as a query
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL_REJ   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_REJ  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } t_dq_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   front_value;
        logic [DATA_W-1:0]   rear_value;
        logic                ends_valid;
        logic                is_empty;
        logic                is_full;
        logic [COUNT_W-1:0]  item_count;
    } t_dq_result;

endpackage
`default_nettype wire

[hdl/circular_buffer_deque.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_buffer_deque: double-ended queue in a ring store
// Push/pop at either end of a ring whose wrap point is a programmable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_item (op, value) and raise start; the item is
//   taken at a clock edge where start is high and busy is low. busy stays
//   low: the block takes one item every cycle.
//   Result channel: one result per item, shown on o_result for exactly one
//   cycle with o_result_vld high, in the cycle after the item was taken. The
//   receiver cannot stall, so results are never held back.
//   Throughput is one item per cycle: each item does at most one write to
//   the ring store and reads both ends back, which the two RAM copies
//   (one per end, written together) serve in the same cycle.
//   A write into an entry that is read in the same cycle is forwarded from
//   a register, since the RAM returns the old word in that case.
//   Configuration: i_cfg_we with i_cfg_wdata sets the capacity in use; a
//   value of zero acts as one and one above MAX_DEPTH acts as MAX_DEPTH.
//   Write it only while no result is outstanding.
//   Reset (synchronous, active low): empty deque, both indices at slot 0,
//   capacity = min(1024, MAX_DEPTH). The ring store is not cleared; entries
//   are only read after they have been written.
// ----------------------------------------------------------------------------
module circular_buffer_deque
    import cbd_pkg::*;
#(
    parameter int MAX_DEPTH = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_dq_cmd    i_item,
    output logic            o_result_vld,
    output t_dq_result      o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int AW      = $clog2(MAX_DEPTH);
    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
    localparam int CAP_RST = (MAX_DEPTH < 1024) ? MAX_DEPTH : 1024;

    // Ring indices, fill count and clamped capacity
    logic [AW-1:0]    r_front, n_front;
    logic [AW-1:0]    r_rear,  n_rear;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap,   n_cap;

    // Result stage
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status, n_status;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_full;
    logic                r_fwd_front;
    logic                r_fwd_rear;
    logic [DATA_W-1:0]   r_fwd_data;

    // Store access
    logic              w_accept;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_front_q;
    logic [DATA_W-1:0] w_rear_q;
    logic              w_full;
    logic              w_empty;
    logic [31:0]       w_cfg_ext;

    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i,
                                               input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] wide_i;
        wide_i = (CNT_W+1)'(i);
        return (wide_i >= ((CNT_W+1)'(cap) - 1'b1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i,
                                               input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] last;
        last = cap - 1'b1;
        return (i == '0) ? AW'(last) : i - 1'b1;
    endfunction

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;
    assign w_full   = (r_count >= r_cap);
    assign w_empty  = (r_count == '0);

    // Clamp the capacity when it is written
    assign w_cfg_ext = 32'(i_cfg_wdata);
    always_comb begin
        priority if (w_cfg_ext == 32'd0) begin
            n_cap = CNT_W'(1);
        end else if (w_cfg_ext > 32'(MAX_DEPTH)) begin
            n_cap = CNT_W'(MAX_DEPTH);
        end else begin
            n_cap = CNT_W'(w_cfg_ext);
        end
    end

    // Next indices, count and store write for the accepted item
    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_status = ST_DONE;
        w_we     = 1'b0;
        w_waddr  = r_front;
        if (w_accept) begin
            unique case (i_item.op)
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (w_full) begin
                        n_status = ST_FULL_REJ;
                    end else begin
                        // Empty deque restarts both ends at slot 0
                        if (w_empty) begin
                            n_front = '0;
                            n_rear  = '0;
                        end else if (i_item.op == OP_PUSH_FRONT) begin
                            n_front = idx_prev(r_front, r_cap);
                        end else begin
                            n_rear  = idx_next(r_rear, r_cap);
                        end
                        w_we    = 1'b1;
                        w_waddr = (i_item.op == OP_PUSH_FRONT) ? n_front : n_rear;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT, OP_POP_REAR: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY_REJ;
                    end else begin
                        // Dropping the last item returns both ends to slot 0
                        if (r_count == CNT_W'(1)) begin
                            n_front = '0;
                            n_rear  = '0;
                        end else if (i_item.op == OP_POP_FRONT) begin
                            n_front = idx_next(r_front, r_cap);
                        end else begin
                            n_rear  = idx_prev(r_rear, r_cap);
                        end
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    // Query and unused codes: report only
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // One RAM copy per end so both ends are read in the same cycle
    cbd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_ram_front (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.value),
        .i_raddr (n_front),
        .o_rdata (w_front_q)
    );

    cbd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_ram_rear (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.value),
        .i_raddr (n_rear),
        .o_rdata (w_rear_q)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_rear    <= '0;
            r_count   <= '0;
            r_cap     <= CNT_W'(CAP_RST);
            r_out_vld <= 1'b0;
        end else begin
            r_front   <= n_front;
            r_rear    <= n_rear;
            r_count   <= n_count;
            r_out_vld <= w_accept;
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
        end
    end

    // Result payload; hold the pushed word for forwarding
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_full   <= (n_count >= r_cap);
            r_fwd_front  <= w_we && (w_waddr == n_front);
            r_fwd_rear   <= w_we && (w_waddr == n_rear);
            r_fwd_data   <= i_item.value;
        end
    end

    always_comb begin
        o_result_vld         = r_out_vld;
        o_result.status      = r_out_status;
        o_result.ends_valid  = (r_out_count != '0);
        o_result.is_empty    = (r_out_count == '0);
        o_result.is_full     = r_out_full;
        o_result.item_count  = COUNT_W'(r_out_count);
        o_result.front_value = '0;
        o_result.rear_value  = '0;
        if (r_out_count != '0) begin
            o_result.front_value = r_fwd_front ? r_fwd_data : w_front_q;
            o_result.rear_value  = r_fwd_rear  ? r_fwd_data : w_rear_q;
        end
    end

`ifndef ASSERT_OFF
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_result_vld)
        else $error("result strobe missing after an accepted item");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_result_vld)
        else $error("result strobe without an accepted item");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DEPTH))
        else $error("item count above the ring depth");

    a_empty_indices_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0 && r_rear == '0))
        else $error("empty deque with an end away from slot 0");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status != ST_DONE) |=> (r_count == $past(r_count)))
        else $error("refused item changed the count");
`endif

endmodule
`default_nettype wire

[hdl/cbd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the entry being
// written returns the old contents.
// ----------------------------------------------------------------------------
module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ring-store deque
// Drives front/rear pushes, pops and queries with random gaps, mirrors the
// deque in a behavioral copy and checks every result field by field. The
// capacity register is swept through its extremes while the deque is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import cbd_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int STALL_LIMIT = 400;   // cycles with no item and no result

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_dq_cmd            cmd_bus     = '0;
    logic               result_vld;
    t_dq_result         result_bus;
    logic               cfg_we      = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata   = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    circular_buffer_deque #(
        .MAX_DEPTH   (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_bus),
        .o_result_vld(result_vld),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the deque: ring, both end indices, fill level and
    // the capacity register as last written.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0]  ring_mem [DEPTH];
    int                 head_idx;
    int                 tail_idx;
    int                 held;
    logic [CFG_W-1:0]   cap_cfg;

    t_dq_cmd            op_backlog [$];     // items waiting for the driver
    t_dq_result         deque_reports [$];  // results owed by the block, oldest first

    int                 gap_ceiling = 14;   // longest pause drawn between items
    int                 gap_left    = 0;
    logic               item_fired  = 1'b0; // the item on the bus was taken last edge
    int                 fail_count  = 0;
    int                 quiet_cycles = 0;

    function automatic int step_fwd(int idx, int lim);
        return (idx >= lim - 1) ? 0 : idx + 1;
    endfunction

    function automatic int step_back(int idx, int lim);
        return (idx == 0) ? lim - 1 : idx - 1;
    endfunction

    // Apply one item to the copy and return the result it should produce.
    function automatic t_dq_result apply_deque_op(t_dq_cmd c);
        t_dq_result r;
        int         lim;
        // A capacity of zero acts as one; anything above the depth clamps.
        lim = (cap_cfg == '0) ? 1 : (int'(cap_cfg) > DEPTH) ? DEPTH : int'(cap_cfg);
        r = '0;
        r.status = ST_DONE;
        case (c.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                // Full also covers a count left above a lowered capacity.
                if (held >= lim) begin
                    r.status = ST_FULL_REJ;
                end else begin
                    // First item of an empty deque always lands in slot 0.
                    if (held == 0) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (c.op == OP_PUSH_FRONT) begin
                        head_idx = step_back(head_idx, lim);
                    end else begin
                        tail_idx = step_fwd(tail_idx, lim);
                    end
                    if (c.op == OP_PUSH_FRONT) begin
                        ring_mem[head_idx] = c.value;
                    end else begin
                        ring_mem[tail_idx] = c.value;
                    end
                    held++;
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (held == 0) begin
                    r.status = ST_EMPTY_REJ;
                end else begin
                    // Taking the last item sends both ends back to slot 0.
                    if (held == 1) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (c.op == OP_POP_FRONT) begin
                        head_idx = step_fwd(head_idx, lim);
                    end else begin
                        tail_idx = step_back(tail_idx, lim);
                    end
                    held--;
                end
            end
            default: begin
                // Query and the unused codes leave the deque untouched.
            end
        endcase
        if (held != 0) begin
            r.front_value = ring_mem[head_idx];
            r.rear_value  = ring_mem[tail_idx];
            r.ends_valid  = 1'b1;
        end
        r.is_empty   = (held == 0);
        r.is_full    = (held >= lim);
        r.item_count = COUNT_W'(held);
        return r;
    endfunction

    task automatic flag_field(string name, logic [DATA_W-1:0] want,
                              logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present items from the backlog at the falling edge. Hold the
    // item until it is taken, then pause for the drawn number of cycles.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!start || item_fired) begin
            if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (op_backlog.size() != 0) begin
                cmd_bus  <= op_backlog.pop_front();
                start    <= 1'b1;
                gap_left <= $urandom_range(0, gap_ceiling);
            end else begin
                start    <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge check the result on the bus against the
    // oldest owed one first, then predict the item taken at this edge, so a
    // result and a new item in the same cycle are handled in order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dq_result want;
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            held     = 0;
            cap_cfg  = CFG_W'(DEPTH);
            deque_reports.delete();
            item_fired <= 1'b0;
        end else begin
            if (result_vld) begin
                if (deque_reports.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count++;
                end else begin
                    want = deque_reports.pop_front();
                    flag_field("status",      DATA_W'(want.status), DATA_W'(result_bus.status));
                    flag_field("front_value", want.front_value,     result_bus.front_value);
                    flag_field("rear_value",  want.rear_value,      result_bus.rear_value);
                    flag_field("ends_valid",  DATA_W'(want.ends_valid),
                               DATA_W'(result_bus.ends_valid));
                    flag_field("is_empty",    DATA_W'(want.is_empty),
                               DATA_W'(result_bus.is_empty));
                    flag_field("is_full",     DATA_W'(want.is_full),
                               DATA_W'(result_bus.is_full));
                    flag_field("item_count",  DATA_W'(want.item_count),
                               DATA_W'(result_bus.item_count));
                end
            end
            if (start && !busy) begin
                deque_reports.push_back(apply_deque_op(cmd_bus));
            end
            if (cfg_we) begin
                cap_cfg = cfg_wdata;
            end
            item_fired <= start && !busy;
        end
    end

    // Watchdog: drop the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || result_vld) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_item(logic [OP_W-1:0] code, logic [DATA_W-1:0] word);
        t_dq_cmd c;
        c.op    = code;
        c.value = word;
        op_backlog.push_back(c);
    endtask

    // Hold until every item is taken and every result has come back.
    task automatic wait_idle();
        while (op_backlog.size() != 0 || start || deque_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Empty the deque with pops at random ends so that the next capacity
    // takes effect on an empty ring and no unwritten slot is ever read.
    task automatic drain_deque();
        int n;
        wait_idle();
        n = held;
        repeat (n) begin
            queue_item($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, $urandom());
        end
        wait_idle();
    endtask

    // Random ops: push_pct percent pushes, a few queries and unused codes,
    // the rest pops.
    task automatic queue_random(int n, int push_pct);
        int              r;
        logic [OP_W-1:0] code;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                code = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            end else if (r < 94) begin
                code = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            end else begin
                code = OP_QUERY + OP_W'($urandom_range(0, 3));
            end
            queue_item(code, $urandom());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset, directed corner cases, then random phases, each at a
    // new capacity written while the deque is empty and idle.
    // ------------------------------------------------------------------------
    initial begin
        int cap_plan [11];
        cap_plan = '{0, 1, 2, 2047, 3, 7, 1024, 16, 5, 100, 1};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty deque at reset capacity: query is answered, both pops are refused.
        queue_item(OP_QUERY, 32'h0);
        queue_item(OP_POP_FRONT, 32'hFFFF_FFFF);
        queue_item(OP_POP_REAR, 32'h0);
        // Fill slots 0..7 from the rear, data extremes first.
        queue_item(OP_PUSH_REAR, 32'hFFFF_FFFF);
        queue_item(OP_PUSH_REAR, 32'h0);
        repeat (6) queue_item(OP_PUSH_REAR, $urandom());
        // Unused op codes act as a query.
        queue_item(OP_QUERY + 3'd1, $urandom());
        queue_item(OP_QUERY + 3'd2, $urandom());
        queue_item(OP_QUERY + 3'd3, $urandom());
        wait_idle();

        // Lower the capacity under the count: pushes refused, pops work, and
        // the rear index beyond the new wrap point steps to 0 on a push.
        write_capacity(CFG_W'(4));
        queue_item(OP_PUSH_FRONT, $urandom());
        queue_item(OP_PUSH_REAR, $urandom());
        queue_item(OP_QUERY, $urandom());
        repeat (5) queue_item(OP_POP_FRONT, $urandom());
        queue_item(OP_PUSH_REAR, $urandom());
        queue_item(OP_PUSH_FRONT, $urandom());
        queue_item(OP_POP_REAR, $urandom());

        foreach (cap_plan[p]) begin
            drain_deque();
            write_capacity(CFG_W'(cap_plan[p]));
            // Every third phase runs back to back with no pauses.
            gap_ceiling = (p % 3 == 1) ? 0 : 14;
            queue_random(60, (cap_plan[p] > 100) ? 75 : $urandom_range(35, 65));
        end
        wait_idle();

        if (fail_count == 0 && deque_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
